// ===== rtl/core/swst_pkg.sv =====
// ----------------------------------------------------------------------------
// swst_pkg - shared types and constants of the send window slot table
// Slot count, sequence width, action codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package swst_pkg;

  // Built table size and sequence number width
  localparam int SLOT_COUNT = 8;
  localparam int SEQ_BITS   = 16;

  // Derived widths: slot index, and a count that can hold SLOT_COUNT
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the stream words
  localparam int ACT_W     = 2;
  localparam int SEQ_IN_W  = 16;
  localparam int WIN_W     = 4;
  localparam int SLOT_O_W  = 3;
  localparam int HIGH_O_W  = 16;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT   = 2'd0,
    ACT_SLIDE  = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming word
    logic fill;    // one add step of an init
    logic commit;  // finish the word and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_fill;    // incoming word is an init with a non-empty window
    logic fill_last;  // current add step is the last of the init
  } dp_status_t;

endpackage

// ===== rtl/core/swst_dp.sv =====
// ----------------------------------------------------------------------------
// swst_dp - slot table datapath
// Slot flags and sequence numbers, highest admitted number, window
// register, parallel free/match search and the result register.
// ----------------------------------------------------------------------------
module swst_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swst_pkg::WIN_W-1:0]     cfg_wdata_i,
  input  logic [swst_pkg::ACT_W-1:0]     in_action_i,
  input  logic [swst_pkg::SEQ_IN_W-1:0]  in_seq_i,
  input  swst_pkg::dp_cmd_t              cmd_i,
  output swst_pkg::dp_status_t           status_o,
  output logic                           out_ok_o,
  output logic [swst_pkg::SLOT_O_W-1:0]  out_slot_o,
  output logic [swst_pkg::HIGH_O_W-1:0]  out_highest_o
);
  import swst_pkg::*;

  logic [WIN_W-1:0]      win_cfg_q;
  logic [SLOT_COUNT-1:0] used_q;
  logic [SEQ_BITS-1:0]   slot_seq_q [SLOT_COUNT];
  logic [SEQ_BITS-1:0]   max_seq_q, max_seq_d;
  action_e               action_q;
  logic [SEQ_BITS-1:0]   seq_q;
  logic [IDX_W-1:0]      k_q;
  logic                  fill_ok_q, fill_ok_d;
  logic [IDX_W-1:0]      first_slot_q, first_slot_d;
  logic                  out_ok_q;
  logic [SLOT_O_W-1:0]   out_slot_q;
  logic [HIGH_O_W-1:0]   out_highest_q;

  logic [CNT_W-1:0]      win_cnt;
  logic [SLOT_COUNT-1:0] active, free_vec, match_vec;
  logic [IDX_W-1:0]      free_idx, match_idx;
  logic                  free_any, match_any;
  logic [SEQ_BITS-1:0]   add_seq;
  logic                  add_en, clr_en;
  logic                  res_ok;
  logic [IDX_W-1:0]      res_slot;
  logic [SEQ_BITS-1:0]   res_max;

  // Window clamped to the built slot count
  assign win_cnt = (32'(win_cfg_q) < SLOT_COUNT) ? CNT_W'(win_cfg_q) : CNT_W'(SLOT_COUNT);

  // Parallel search over all slots, lowest index wins
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      active[i]    = (i < int'(win_cnt));
      free_vec[i]  = active[i] & ~used_q[i];
      match_vec[i] = active[i] & used_q[i] & (slot_seq_q[i] == seq_q);
    end
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = IDX_W'(i);
      if (match_vec[i]) match_idx = IDX_W'(i);
    end
    free_any  = |free_vec;
    match_any = |match_vec;
  end

  // Number to add: next init number while filling, else highest + 1
  assign add_seq = cmd_i.fill ? (seq_q + SEQ_BITS'(k_q)) : (max_seq_q + SEQ_BITS'(1));
  assign add_en  = (cmd_i.fill | (cmd_i.commit & (action_q == ACT_SLIDE))) & free_any;
  assign clr_en  = cmd_i.commit & (action_q == ACT_REMOVE) & match_any;

  // Result of the word at commit
  always_comb begin
    res_ok   = 1'b0;
    res_slot = '0;
    res_max  = max_seq_q;
    case (action_q)
      ACT_INIT: begin
        res_ok   = fill_ok_q;
        res_slot = first_slot_q;
        res_max  = seq_q + SEQ_BITS'(win_cnt) - SEQ_BITS'(1);
      end
      ACT_SLIDE: begin
        res_ok   = free_any;
        res_slot = free_idx;
        if (free_any) res_max = max_seq_q + SEQ_BITS'(1);
      end
      ACT_LOOKUP, ACT_REMOVE: begin
        res_ok   = match_any;
        res_slot = match_idx;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign max_seq_d = cmd_i.commit ? res_max : max_seq_q;

  // Init bookkeeping per add step
  always_comb begin
    fill_ok_d    = fill_ok_q;
    first_slot_d = first_slot_q;
    if (cmd_i.fill) begin
      if (!free_any) fill_ok_d = 1'b0;
      if ((k_q == '0) && free_any) first_slot_d = free_idx;
    end
    if (cmd_i.load) begin
      fill_ok_d    = 1'b1;
      first_slot_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q    <= WIN_RESET;
      used_q       <= '0;
      max_seq_q    <= '0;
      action_q     <= ACT_INIT;
      k_q          <= '0;
      fill_ok_q    <= 1'b1;
      first_slot_q <= '0;
    end else begin
      if (cfg_we_i) win_cfg_q <= cfg_wdata_i;
      if (add_en) used_q[free_idx] <= 1'b1;
      if (clr_en) used_q[match_idx] <= 1'b0;
      max_seq_q    <= max_seq_d;
      fill_ok_q    <= fill_ok_d;
      first_slot_q <= first_slot_d;
      if (cmd_i.load) begin
        action_q <= action_e'(in_action_i);
        k_q      <= '0;
      end else if (cmd_i.fill) begin
        k_q <= k_q + IDX_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (add_en) slot_seq_q[free_idx] <= add_seq;
    if (cmd_i.load) seq_q <= SEQ_BITS'(in_seq_i);
    if (cmd_i.commit) begin
      out_ok_q      <= res_ok;
      out_slot_q    <= res_ok ? SLOT_O_W'(res_slot) : '0;
      out_highest_q <= HIGH_O_W'(max_seq_d);
    end
  end

  // Status to controller
  assign status_o.in_fill   = (action_e'(in_action_i) == ACT_INIT) && (win_cnt != '0);
  assign status_o.fill_last = ((CNT_W'(k_q) + CNT_W'(1)) == win_cnt);

  assign out_ok_o      = out_ok_q;
  assign out_slot_o    = out_slot_q;
  assign out_highest_o = out_highest_q;

endmodule

// ===== rtl/core/swst_ctrl.sv =====
// ----------------------------------------------------------------------------
// swst_ctrl - slot table controller
// Sequences accept, init fill steps and commit, and owns the result
// valid flag of the output register.
// ----------------------------------------------------------------------------
module swst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  swst_pkg::dp_status_t status_i,
  output swst_pkg::dp_cmd_t    cmd_o
);
  import swst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  // State and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign can_load = ~out_valid_q | out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_fill ? S_FILL : S_DONE;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          cmd_o.commit = 1'b1;
          in_ready_o   = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = status_i.in_fill ? S_FILL : S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on commit, cleared when the word is taken
  assign out_valid_d = cmd_o.commit | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not fill the result register");
  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> !in_ready_o)
    else $error("word accepted during init fill");
  a_fill_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fill && status_i.fill_last) |=> (state_q == S_DONE))
    else $error("init fill did not move to commit");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.commit)
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== rtl/core/send_window_slot_table.sv =====
// Slide, lookup and remove are latched when taken and committed to the result register once
// the previous result is taken; an init with W = min(window_size, SLOT_COUNT) active slots
// fills them first. Throughput: one slide, lookup or remove per cycle while results are
// drained; an init holds the input during its fill, one slot add per cycle through the
// shared free search. Reset: asynchronous, all slots free, highest number zero, window_size 8.
// ----------------------------------------------------------------------------
// send_window_slot_table - sliding window sender slot table
// Stream top level: controller and datapath, config write port.
// ----------------------------------------------------------------------------
module send_window_slot_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,    // window_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] seq_num
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] slot_index, [18:3] highest_seq, rest zero
  output logic        m_axis_tuser    // [0] ok
);
  import swst_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [SLOT_O_W-1:0]  out_slot;
  logic [HIGH_O_W-1:0]  out_highest;

  swst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_action_i   (s_axis_tuser),
    .in_seq_i      (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ok_o      (m_axis_tuser),
    .out_slot_o    (out_slot),
    .out_highest_o (out_highest)
  );

  assign m_axis_tdata = {5'd0, out_highest, out_slot};

endmodule

// ===== tb/send_window_slot_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_window_slot_table_test - self-checking bench for the slot table
// Drives init, slide, lookup and remove words through the input stream and
// predicts every result word from a bench-side copy of the slot table,
// under several window sizes and with random stalls on both streams.
// ----------------------------------------------------------------------------
module send_window_slot_table_test;
  import swst_pkg::*;

  // One result word: ok flag, slot number, highest admitted sequence number
  typedef struct packed {
    logic                ok;
    logic [SLOT_O_W-1:0] slot;
    logic [HIGH_O_W-1:0] highest;
  } slot_result_t;

  // Bench copy of the slot table plus the queue of results still owed
  class slot_table_scoreboard;
    logic [WIN_W-1:0]    win_reg;
    bit                  used[SLOT_COUNT];
    logic [SEQ_BITS-1:0] seq_of[SLOT_COUNT];
    logic [SEQ_BITS-1:0] high_seq;
    slot_result_t        owed_results[$];
    int                  mismatches;
    int                  words_checked;
    int                  hits;
    int                  action_count[4];

    function new();
      win_reg  = WIN_RESET;
      high_seq = '0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      win_reg = value;
    endfunction

    function int active_slots();
      return (win_reg < SLOT_COUNT) ? int'(win_reg) : SLOT_COUNT;
    endfunction

    // Lowest free active slot takes the number; -1 when the window is full
    function int claim_free(logic [SEQ_BITS-1:0] seq);
      for (int i = 0; i < active_slots(); i++) begin
        if (!used[i]) begin
          used[i]   = 1'b1;
          seq_of[i] = seq;
          return i;
        end
      end
      return -1;
    endfunction

    function int match_slot(logic [SEQ_BITS-1:0] seq);
      for (int i = 0; i < active_slots(); i++)
        if (used[i] && seq_of[i] == seq) return i;
      return -1;
    endfunction

    // A number held in some active slot, for lookups and removes that hit
    function bit live_seq(output logic [SEQ_BITS-1:0] seq);
      int cand[$];
      for (int i = 0; i < active_slots(); i++)
        if (used[i]) cand.push_back(i);
      if (cand.size() == 0) return 1'b0;
      seq = seq_of[cand[$urandom_range(cand.size() - 1)]];
      return 1'b1;
    endfunction

    // Apply one accepted input word and queue the result it must give
    function void note_request(action_e act, logic [SEQ_BITS-1:0] seq);
      slot_result_t r;
      int w;
      int s;
      int first;
      r.ok  = 1'b0;
      s     = -1;
      action_count[act]++;
      case (act)
        ACT_INIT: begin
          w     = active_slots();
          r.ok  = 1'b1;
          first = -1;
          for (int k = 0; k < w; k++) begin
            s = claim_free(SEQ_BITS'(seq + k));
            if (s < 0) r.ok = 1'b0;
            else if (k == 0) first = s;
          end
          high_seq = SEQ_BITS'(seq + w - 1);
          s = first;
        end
        ACT_SLIDE: begin
          s = claim_free(SEQ_BITS'(high_seq + 1));
          if (s >= 0) begin
            high_seq = SEQ_BITS'(high_seq + 1);
            r.ok     = 1'b1;
          end
        end
        default: begin
          s = match_slot(seq);
          if (s >= 0) begin
            r.ok = 1'b1;
            if (act == ACT_REMOVE) used[s] = 1'b0;
          end
        end
      endcase
      r.slot    = (r.ok && s >= 0) ? SLOT_O_W'(s) : '0;
      r.highest = high_seq;
      if (r.ok) hits++;
      owed_results.push_back(r);
    endfunction

    // Compare one result word with the oldest owed result
    function void check_response(logic ok, logic [SLOT_O_W-1:0] slot,
                                 logic [HIGH_O_W-1:0] highest);
      slot_result_t want;
      words_checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d with none owed: ok=%0d slot=%0d high=%04h",
                   words_checked, ok, slot, highest);
        return;
      end
      want = owed_results.pop_front();
      if (want.ok !== ok || want.slot !== slot || want.highest !== highest) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: expected ok=%0d slot=%0d high=%04h, got ok=%0d slot=%0d high=%04h",
                   words_checked, want.ok, want.slot, want.highest, ok, slot, highest);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] seq_num
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] slot_index, [18:3] highest_seq
  logic        m_axis_tuser;   // [0] ok

  slot_table_scoreboard sb = new();
  int tx_idle_pct = 35;
  int rx_idle_pct = 64;
  int windows_used;

  send_window_slot_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #4ms;
    $display("send_window_slot_table: mismatch");
    $finish;
  end

  // Result side: random back-pressure, check each word taken
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_response(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3]);
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(action_e act, logic [15:0] seq);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(act, seq);
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_window(logic [3:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(value);
    windows_used++;
  endtask

  // Mostly slides and hitting lookups/removes, some inits and misses
  task automatic send_random_word();
    int pick;
    action_e act;
    logic [15:0] seq;
    pick = $urandom_range(99);
    seq  = 16'($urandom);
    if (pick < 4) begin
      act = ACT_INIT;
      if ($urandom_range(1)) seq = 16'hFFF8 + 16'($urandom_range(7));
    end else if (pick < 34) begin
      act = ACT_SLIDE;
    end else begin
      act = (pick < 64) ? ACT_LOOKUP : ACT_REMOVE;
      if ($urandom_range(9) < 8) begin
        if (!sb.live_seq(seq)) seq = sb.high_seq;
      end else if ($urandom_range(1)) begin
        seq = sb.high_seq;
      end
    end
    send_word(act, seq);
  endtask

  // Stimulus
  initial begin
    int win_plan[10];
    int tx_plan[3];
    int rx_plan[3];
    win_plan = '{8, 4, 1, 15, 0, 6, 8, 2, 7, 3};
    tx_plan  = '{35, 64, 0};
    rx_plan  = '{64, 35, 0};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_INIT;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, wrap on init, full table, duplicate numbers
    send_word(ACT_LOOKUP, 16'h0000);
    send_word(ACT_SLIDE,  16'hFFFF);
    send_word(ACT_INIT,   16'hFFFC);
    send_word(ACT_SLIDE,  16'h0000);
    send_word(ACT_LOOKUP, 16'hFFFF);
    send_word(ACT_LOOKUP, 16'h0000);
    send_word(ACT_REMOVE, 16'hFFFF);
    send_word(ACT_REMOVE, 16'hFFFF);
    send_word(ACT_SLIDE,  16'h5555);
    send_word(ACT_LOOKUP, 16'h0001);
    send_word(ACT_REMOVE, 16'h0001);
    send_word(ACT_LOOKUP, 16'h0001);
    // Zero window: only init succeeds
    write_window(4'd0);
    send_word(ACT_INIT,   16'h1234);
    send_word(ACT_SLIDE,  16'hAAAA);
    send_word(ACT_LOOKUP, 16'h0001);
    send_word(ACT_REMOVE, 16'h0001);
    // Shrunk window hides the upper slots, regrowing shows them again
    write_window(4'd2);
    send_word(ACT_LOOKUP, 16'hFFFD);
    send_word(ACT_SLIDE,  16'h0000);
    send_word(ACT_SLIDE,  16'h0000);
    write_window(4'd15);
    send_word(ACT_LOOKUP, 16'hFFFD);
    send_word(ACT_INIT,   16'h0000);

    // Random: three stall regimes, each over the window plan
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_plan[p];
      rx_idle_pct = rx_plan[p];
      foreach (win_plan[w]) begin
        write_window(4'(win_plan[w]));
        for (int n = 0; n < 58; n++) begin
          if (n == 29) drain_results();
          send_random_word();
        end
      end
    end

    drain_results();
    if (sb.owed_results.size() != 0) sb.mismatches += sb.owed_results.size();
    $display("checked %0d result words (%0d ok) over %0d window writes",
             sb.words_checked, sb.hits, windows_used);
    $display("actions: %0d init, %0d slide, %0d lookup, %0d remove; %0d failures",
             sb.action_count[ACT_INIT], sb.action_count[ACT_SLIDE],
             sb.action_count[ACT_LOOKUP], sb.action_count[ACT_REMOVE], sb.mismatches);
    if (sb.mismatches == 0)
      $display("send_window_slot_table: match");
    else
      $display("send_window_slot_table: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/swst_pkg.sv
rtl/core/swst_dp.sv
rtl/core/swst_ctrl.sv
rtl/core/send_window_slot_table.sv
tb/send_window_slot_table_test.sv
